[rtl/vlr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlr_pkg
// Shared types and constants of the vector line rasterizer.
// ----------------------------------------------------------------------------
package vlr_pkg;

   // Item mode codes as they arrive on the request channel
   localparam logic [1:0] MODE_MOVE = 2'd0;
   localparam logic [1:0] MODE_DRAW = 2'd1;
   localparam logic [1:0] MODE_STEP = 2'd2;

   localparam int MODE_BITS  = 2;
   localparam int DWELL_BITS = 16;

   // Command queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   // Classified command handed from front to back
   typedef enum logic [1:0] {
      CMD_MOVE,
      CMD_DRAW,
      CMD_STEP,
      CMD_NOP
   } cmd_kind_type;

endpackage

`default_nettype wire

[rtl/vlr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlr_front
// Accepts request items, classifies the mode and queues commands for the back.
// ----------------------------------------------------------------------------
module vlr_front #(
   parameter int COORD_BITS = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  wire  [1:0]               in_mode,
   input  wire  [COORD_BITS-1:0]    in_tx,
   input  wire  [COORD_BITS-1:0]    in_ty,
   output logic                     q_valid,
   input  wire                      q_ready,
   output vlr_pkg::cmd_kind_type    q_kind,
   output logic [COORD_BITS-1:0]    q_tx,
   output logic [COORD_BITS-1:0]    q_ty
);
   import vlr_pkg::*;

   cmd_kind_type                 kind_mem_ff [QUEUE_DEPTH];
   logic [COORD_BITS-1:0]        tx_mem_ff   [QUEUE_DEPTH];
   logic [COORD_BITS-1:0]        ty_mem_ff   [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]    count_ff, count_in;
   cmd_kind_type                 kind;
   logic                         push;
   logic                         pop;

   always_comb begin
      unique case (in_mode)
         MODE_MOVE: kind = CMD_MOVE;
         MODE_DRAW: kind = CMD_DRAW;
         MODE_STEP: kind = CMD_STEP;
         default:   kind = CMD_NOP;
      endcase
   end

   assign in_ready = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != '0);
   assign pop      = q_valid && q_ready;
   assign q_kind   = kind_mem_ff[rd_ptr_ff];
   assign q_tx     = tx_mem_ff[rd_ptr_ff];
   assign q_ty     = ty_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_mem_ff[wr_ptr_ff] <= kind;
         tx_mem_ff[wr_ptr_ff]   <= in_tx;
         ty_mem_ff[wr_ptr_ff]   <= in_ty;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QUEUE_CNT_BITS'(1)) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");
`endif

endmodule

`default_nettype wire

[rtl/vlr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlr_back
// Executes queued commands: beam position, Bresenham stepping, point output.
// ----------------------------------------------------------------------------
module vlr_back #(
   parameter int COORD_BITS = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_we,
   input  wire  [15:0]              csr_wdata,
   input  wire                      q_valid,
   output logic                     q_ready,
   input  vlr_pkg::cmd_kind_type    q_kind,
   input  wire  [COORD_BITS-1:0]    q_tx,
   input  wire  [COORD_BITS-1:0]    q_ty,
   output logic                     out_valid,
   input  wire                      out_ready,
   output logic [COORD_BITS-1:0]    out_x,
   output logic [COORD_BITS-1:0]    out_y,
   output logic                     out_laser,
   output logic [16:0]              out_dwell,
   output logic                     out_last,
   output logic                     out_point_valid
);
   import vlr_pkg::*;

   localparam int ERR_W = COORD_BITS + 3;

   logic [DWELL_BITS-1:0]     point_dwell_ff;
   logic [COORD_BITS-1:0]     cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]     end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic [COORD_BITS-1:0]     span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic                      x_major_ff, x_major_in;
   logic [1:0]                dirs_ff, dirs_in;
   logic                      active_ff, active_in;

   logic                      out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]     out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                      out_laser_ff, out_laser_in;
   logic [16:0]               out_dwell_ff, out_dwell_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_pv_ff, out_pv_in;

   logic                      fire;
   logic                      xneg, yneg, xm;
   logic [COORD_BITS-1:0]     sx, sy, nx, ny;
   logic signed [ERR_W-1:0]   two_sx, two_sy, one_sx, one_sy;
   logic signed [ERR_W-1:0]   two_span_x, two_span_y;
   logic                      minor, done;
   logic [16:0]               dwell2;

   assign q_ready = !out_valid_ff || out_ready;
   assign fire    = q_valid && q_ready;
   assign dwell2  = {point_dwell_ff, 1'b0};

   // Draw set-up from the current beam position
   always_comb begin
      xneg   = q_tx < cur_x_ff;
      yneg   = q_ty < cur_y_ff;
      sx     = xneg ? cur_x_ff - q_tx : q_tx - cur_x_ff;
      sy     = yneg ? cur_y_ff - q_ty : q_ty - cur_y_ff;
      xm     = sy <= sx;
      two_sx = $signed({2'b00, sx, 1'b0});
      two_sy = $signed({2'b00, sy, 1'b0});
      one_sx = $signed({3'b000, sx});
      one_sy = $signed({3'b000, sy});
   end

   // One Bresenham step
   always_comb begin
      two_span_x = $signed({2'b00, span_x_ff, 1'b0});
      two_span_y = $signed({2'b00, span_y_ff, 1'b0});
      if (x_major_ff) begin
         minor = !err_ff[ERR_W-1];
      end else begin
         minor = !err_ff[ERR_W-1] && (err_ff != '0);
      end
      nx = cur_x_ff;
      ny = cur_y_ff;
      if (x_major_ff || minor) begin
         nx = dirs_ff[0] ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      end
      if (!x_major_ff || minor) begin
         ny = dirs_ff[1] ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
      end
      done = x_major_ff ? (nx == end_x_ff) : (ny == end_y_ff);
   end

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      err_in       = err_ff;
      x_major_in   = x_major_ff;
      dirs_in      = dirs_ff;
      active_in    = active_ff;
      out_valid_in = q_ready ? q_valid : out_valid_ff;
      out_x_in     = '0;
      out_y_in     = '0;
      out_laser_in = 1'b0;
      out_dwell_in = '0;
      out_last_in  = 1'b0;
      out_pv_in    = 1'b0;
      if (fire) begin
         unique case (q_kind)
            CMD_MOVE: begin
               cur_x_in    = q_tx;
               cur_y_in    = q_ty;
               active_in   = 1'b0;
               out_x_in    = q_tx;
               out_y_in    = q_ty;
               out_last_in = 1'b1;
               out_pv_in   = 1'b1;
            end
            CMD_DRAW: begin
               span_x_in    = sx;
               span_y_in    = sy;
               dirs_in      = {yneg, xneg};
               x_major_in   = xm;
               err_in       = xm ? two_sy - one_sx : two_sx - one_sy;
               end_x_in     = q_tx;
               end_y_in     = q_ty;
               active_in    = (q_tx != cur_x_ff) || (q_ty != cur_y_ff);
               out_x_in     = cur_x_ff;
               out_y_in     = cur_y_ff;
               out_laser_in = 1'b1;
               out_dwell_in = dwell2;
               out_last_in  = (q_tx == cur_x_ff) && (q_ty == cur_y_ff);
               out_pv_in    = 1'b1;
            end
            CMD_STEP: begin
               if (active_ff) begin
                  cur_x_in = nx;
                  cur_y_in = ny;
                  if (x_major_ff) begin
                     err_in = minor ? err_ff + two_span_y - two_span_x
                                    : err_ff + two_span_y;
                  end else begin
                     err_in = minor ? err_ff + two_span_x - two_span_y
                                    : err_ff + two_span_x;
                  end
                  active_in    = !done;
                  out_x_in     = nx;
                  out_y_in     = ny;
                  out_laser_in = 1'b1;
                  out_dwell_in = dwell2;
                  out_last_in  = done;
                  out_pv_in    = 1'b1;
               end
            end
            default: begin
               // reserved mode: invalid point, state untouched
               out_pv_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_dwell_ff <= DWELL_BITS'(1);
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         end_x_ff       <= '0;
         end_y_ff       <= '0;
         span_x_ff      <= '0;
         span_y_ff      <= '0;
         err_ff         <= '0;
         x_major_ff     <= 1'b0;
         dirs_ff        <= '0;
         active_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            point_dwell_ff <= csr_wdata;
         end
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         span_x_ff    <= span_x_in;
         span_y_ff    <= span_y_in;
         err_ff       <= err_in;
         x_major_ff   <= x_major_in;
         dirs_ff      <= dirs_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the result while the consumer stalls
   always_ff @(posedge clock) begin
      if (fire) begin
         out_x_ff     <= out_x_in;
         out_y_ff     <= out_y_in;
         out_laser_ff <= out_laser_in;
         out_dwell_ff <= out_dwell_in;
         out_last_ff  <= out_last_in;
         out_pv_ff    <= out_pv_in;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_x           = out_x_ff;
   assign out_y           = out_y_ff;
   assign out_laser       = out_laser_ff;
   assign out_dwell       = out_dwell_ff;
   assign out_last        = out_last_ff;
   assign out_point_valid = out_pv_ff;

`ifndef ASSERT_OFF
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_pv_ff) |-> (out_x_ff == '0 && out_y_ff == '0 &&
         !out_laser_ff && out_dwell_ff == '0 && !out_last_ff))
      else $error("invalid point carries payload");
   a_move_point: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_pv_ff && !out_laser_ff) |-> (out_last_ff && out_dwell_ff == '0))
      else $error("move point not last or has dwell");
   a_active_major: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (x_major_ff ? (cur_x_ff != end_x_ff) : (cur_y_ff != end_y_ff)))
      else $error("line active at its end");
`endif

endmodule

`default_nettype wire

[rtl/vector_line_rasterizer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_line_rasterizer_core
// Laser scanner point generator: moves, Bresenham line draws and steps.
// ----------------------------------------------------------------------------
// Takes one item per clock while the queue has room and gives one point per
// item, so a line comes out at one point per cycle while rsp_tready is high.
// Items pass the two-entry command queue of the front end, then the output
// register of the back end. A step updates and sign-tests the error term,
// which sets the rate. Write point_dwell only while the block is idle.
// ----------------------------------------------------------------------------
module vector_line_rasterizer_core #(
   parameter int COORD_BITS = 8
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_we,
   input  wire  [15:0]                           csr_wdata,  // point_dwell
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // target_x, target_y
   input  wire  [8*((2*COORD_BITS+7)/8)-1:0]     req_tdata,
   input  wire  [1:0]                            req_tuser,  // mode
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // point_x, point_y, laser_on, dwell
   output logic [8*((2*COORD_BITS+25)/8)-1:0]    rsp_tdata,
   output logic                                  rsp_tlast,  // last_point
   output logic                                  rsp_tuser   // point_valid
);
   import vlr_pkg::*;

   localparam int RSP_W   = 2 * COORD_BITS + 18;
   localparam int RSP_PAD = 8 * ((2 * COORD_BITS + 25) / 8) - RSP_W;

   logic                   q_valid;
   logic                   q_ready;
   cmd_kind_type           q_kind;
   logic [COORD_BITS-1:0]  q_tx;
   logic [COORD_BITS-1:0]  q_ty;
   logic [COORD_BITS-1:0]  pt_x;
   logic [COORD_BITS-1:0]  pt_y;
   logic                   pt_laser;
   logic [16:0]            pt_dwell;

   vlr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_mode  (req_tuser),
      .in_tx    (req_tdata[COORD_BITS-1:0]),
      .in_ty    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_kind   (q_kind),
      .q_tx     (q_tx),
      .q_ty     (q_ty)
   );

   vlr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .q_valid         (q_valid),
      .q_ready         (q_ready),
      .q_kind          (q_kind),
      .q_tx            (q_tx),
      .q_ty            (q_ty),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_x           (pt_x),
      .out_y           (pt_y),
      .out_laser       (pt_laser),
      .out_dwell       (pt_dwell),
      .out_last        (rsp_tlast),
      .out_point_valid (rsp_tuser)
   );

   generate
      if (RSP_PAD > 0) begin : g_pad
         assign rsp_tdata = {{RSP_PAD{1'b0}}, pt_dwell, pt_laser, pt_y, pt_x};
      end else begin : g_nopad
         assign rsp_tdata = {pt_dwell, pt_laser, pt_y, pt_x};
      end
   endgenerate

endmodule

`default_nettype wire
